// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, skipped while reset is high.
`define GSR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset cycles included.
`define GSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/gsr_pkg.sv =====
// ----------------------------------------------------------------------------
// gsr_pkg
// Shared constants, operation codes and control types of the slot registry.
// ----------------------------------------------------------------------------
package gsr_pkg;

  localparam int DEF_CHANNEL_COUNT     = 64;
  localparam int DEF_SLOTS_PER_CHANNEL = 8;

  // Fixed field widths of the transfer payloads.
  localparam int OP_W        = 2;
  localparam int CH_W        = 8;
  localparam int HSLOT_W     = 4;
  localparam int GEN_W       = 32;
  localparam int TOTAL_OUT_W = 10;
  localparam int INUSE_OUT_W = 7;
  localparam int REJ_W       = 32;

  typedef enum logic [OP_W-1:0] {
    OP_SUBSCRIBE   = 2'd0,
    OP_UNSUBSCRIBE = 2'd1,
    OP_CLEAR       = 2'd2
  } op_t;

  // Controls from the sequencer to the row store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
  } store_ctl_t;

endpackage

// ===== sv/gsr_channels.sv =====
// ----------------------------------------------------------------------------
// gsr_channels
// Request and response channel interfaces of the slot registry.
// ----------------------------------------------------------------------------
interface gsr_req_if import gsr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [CH_W-1:0]    channel;
  logic [HSLOT_W-1:0] handle_slot;
  logic [GEN_W-1:0]   handle_generation;
  logic               handle_active;

  modport source (output valid, operation, channel, handle_slot, handle_generation,
                  handle_active, input ready);
  modport sink   (input valid, operation, channel, handle_slot, handle_generation,
                  handle_active, output ready);
endinterface

interface gsr_rsp_if import gsr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   accepted;
  logic [CH_W-1:0]        out_channel;
  logic [HSLOT_W-1:0]     out_slot;
  logic [GEN_W-1:0]       out_generation;
  logic                   out_active;
  logic [TOTAL_OUT_W-1:0] total_handlers;
  logic [INUSE_OUT_W-1:0] channels_in_use;
  logic [REJ_W-1:0]       rejected_count;

  modport source (output valid, accepted, out_channel, out_slot, out_generation,
                  out_active, total_handlers, channels_in_use, rejected_count,
                  input ready);
  modport sink   (input valid, accepted, out_channel, out_slot, out_generation,
                  out_active, total_handlers, channels_in_use, rejected_count,
                  output ready);
endinterface

// ===== sv/generational_slot_registry_unit.sv =====
// ----------------------------------------------------------------------------
// generational_slot_registry_unit
// Channel slot registry handing out generation-stamped handles.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transfer: subscribe, unsubscribe or clear,
//   with the channel and, for unsubscribe, the handle to release.
//   rsp returns exactly one result per command: the new handle if any,
//   whether the command took effect, and the running totals.
// Timing:
//   A command reads its channel row at the request transfer and writes it
//   back in the execute state, when the result register is loaded; the result
//   is shown on rsp from that register.
//   A new command is taken only once the last one has written back its channel
//   row in the row memory.
// Reset:
//   Synchronous reset clears the per-row valid flops at once, so every
//   channel reads empty; there is no clearing pass. The generation counter
//   restarts at one, the counters at zero. A clear command does the same
//   except that the generation counter keeps its value.
// Stalls:
//   While a result waits on rsp, the next command is taken only in the cycle
//   in which the waiting result transfers.
// ----------------------------------------------------------------------------
module generational_slot_registry_unit import gsr_pkg::*; #(
  parameter int CHANNEL_COUNT     = DEF_CHANNEL_COUNT,
  parameter int SLOTS_PER_CHANNEL = DEF_SLOTS_PER_CHANNEL
) (
  input  logic      clk,
  input  logic      rst,
  gsr_req_if.sink   req,
  gsr_rsp_if.source rsp
);

  localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  store_ctl_t                              store_ctl;
  logic [CW-1:0]                           rd_addr;
  logic [CW-1:0]                           wr_addr;
  logic [SLOTS_PER_CHANNEL-1:0]            wr_occ;
  logic [SLOTS_PER_CHANNEL-1:0][GEN_W-1:0] wr_gen;
  logic [SLOTS_PER_CHANNEL-1:0]            rd_occ;
  logic [SLOTS_PER_CHANNEL-1:0][GEN_W-1:0] rd_gen;

  gsr_ctrl #(
    .CHANNEL_COUNT     (CHANNEL_COUNT),
    .SLOTS_PER_CHANNEL (SLOTS_PER_CHANNEL)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .store_ctl (store_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_occ    (wr_occ),
    .wr_gen    (wr_gen),
    .rd_occ    (rd_occ),
    .rd_gen    (rd_gen)
  );

  gsr_slot_store #(
    .CHANNEL_COUNT     (CHANNEL_COUNT),
    .SLOTS_PER_CHANNEL (SLOTS_PER_CHANNEL)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (store_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_occ  (wr_occ),
    .wr_gen  (wr_gen),
    .rd_occ  (rd_occ),
    .rd_gen  (rd_gen)
  );

endmodule

// ===== sv/gsr_slot_store.sv =====
// ----------------------------------------------------------------------------
// gsr_slot_store
// Channel row memory: occupancy mask and generation stamps, one row per channel.
// ----------------------------------------------------------------------------
module gsr_slot_store import gsr_pkg::*; #(
  parameter int CHANNEL_COUNT     = DEF_CHANNEL_COUNT,
  parameter int SLOTS_PER_CHANNEL = DEF_SLOTS_PER_CHANNEL,
  localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  store_ctl_t                               ctl,
  input  logic [CW-1:0]                            rd_addr,
  input  logic [CW-1:0]                            wr_addr,
  input  logic [SLOTS_PER_CHANNEL-1:0]             wr_occ,
  input  logic [SLOTS_PER_CHANNEL-1:0][GEN_W-1:0]  wr_gen,
  output logic [SLOTS_PER_CHANNEL-1:0]             rd_occ,
  output logic [SLOTS_PER_CHANNEL-1:0][GEN_W-1:0]  rd_gen
);

  localparam int ROW_W = SLOTS_PER_CHANNEL * (GEN_W + 1);

  logic [ROW_W-1:0]         mem [CHANNEL_COUNT];
  logic [ROW_W-1:0]         rd_row;
  logic                     rd_vld;
  logic [CHANNEL_COUNT-1:0] row_valid;

  // Row memory with registered read data.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= {wr_occ, wr_gen};
    end
    if (ctl.rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

  // A row that was never written since reset or clear reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (ctl.clear_all) begin
        row_valid <= '0;
      end else if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld <= row_valid[rd_addr];
      end
    end
  end

  assign rd_occ = rd_row[ROW_W-1 -: SLOTS_PER_CHANNEL] & {SLOTS_PER_CHANNEL{rd_vld}};
  assign rd_gen = rd_row[SLOTS_PER_CHANNEL*GEN_W-1:0];

endmodule

// ===== sv/gsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsr_ctrl
// Sequencer: reads a channel row, updates it, writes it back when it changes, forms the result.
// ----------------------------------------------------------------------------
module gsr_ctrl import gsr_pkg::*; #(
  parameter int CHANNEL_COUNT     = DEF_CHANNEL_COUNT,
  parameter int SLOTS_PER_CHANNEL = DEF_SLOTS_PER_CHANNEL,
  localparam int CW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
  input  logic                                     clk,
  input  logic                                     rst,
  gsr_req_if.sink                                  req,
  gsr_rsp_if.source                                rsp,
  output store_ctl_t                               store_ctl,
  output logic [CW-1:0]                            rd_addr,
  output logic [CW-1:0]                            wr_addr,
  output logic [SLOTS_PER_CHANNEL-1:0]             wr_occ,
  output logic [SLOTS_PER_CHANNEL-1:0][GEN_W-1:0]  wr_gen,
  input  logic [SLOTS_PER_CHANNEL-1:0]             rd_occ,
  input  logic [SLOTS_PER_CHANNEL-1:0][GEN_W-1:0]  rd_gen
);

  localparam int SW = (SLOTS_PER_CHANNEL > 1) ? $clog2(SLOTS_PER_CHANNEL) : 1;
  localparam int TW = $clog2(CHANNEL_COUNT * SLOTS_PER_CHANNEL + 1);
  localparam int MW = $clog2(CHANNEL_COUNT + 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t             state;
  logic [OP_W-1:0]    op_q;
  logic [CH_W-1:0]    ch_q;
  logic [HSLOT_W-1:0] hslot_q;
  logic [GEN_W-1:0]   hgen_q;
  logic               hact_q;

  logic [GEN_W-1:0]   next_gen;
  logic [MW-1:0]      mark;
  logic [REJ_W-1:0]   rej;
  logic [TW-1:0]      total;

  logic               rsp_valid_q;
  logic               o_acc_q;
  logic [CH_W-1:0]    o_ch_q;
  logic [HSLOT_W-1:0] o_slot_q;
  logic [GEN_W-1:0]   o_gen_q;
  logic               o_act_q;
  logic [TW-1:0]      o_total_q;
  logic [MW-1:0]      o_mark_q;
  logic [REJ_W-1:0]   o_rej_q;

  logic               req_ready;
  logic               req_xfer;
  logic               in_ch_ok;

  logic               wr_c;
  logic               clr_c;
  logic [GEN_W-1:0]   next_gen_next;
  logic [MW-1:0]      mark_next;
  logic [REJ_W-1:0]   rej_next;
  logic [TW-1:0]      total_next;
  logic               acc_c;
  logic [CH_W-1:0]    o_ch_c;
  logic [HSLOT_W-1:0] o_slot_c;
  logic [GEN_W-1:0]   o_gen_c;
  logic               o_act_c;

  // One item at a time; take a new one once the result register can be loaded.
  assign req_ready = (state == S_IDLE) && (!rsp_valid_q || rsp.ready);
  assign req_xfer  = req.valid && req_ready;
  assign req.ready = req_ready;

  // Row read is issued at the transfer of the request.
  assign in_ch_ok = {1'b0, req.channel} < 9'(CHANNEL_COUNT);
  assign rd_addr  = in_ch_ok ? req.channel[CW-1:0] : '0;
  assign wr_addr  = ch_q[CW-1:0];

  assign store_ctl.rd_en     = req_xfer;
  assign store_ctl.wr_en     = (state == S_EXEC) && wr_c;
  assign store_ctl.clear_all = (state == S_EXEC) && clr_c;

  // Row update and counter arithmetic, evaluated while the row data is valid.
  always_comb begin
    logic          ch_ok;
    logic          slot_ok;
    logic          found;
    logic [SW-1:0] free_idx;
    logic [SW-1:0] hs_idx;

    ch_ok    = {1'b0, ch_q} < 9'(CHANNEL_COUNT);
    slot_ok  = {1'b0, hslot_q} < 5'(SLOTS_PER_CHANNEL);
    hs_idx   = hslot_q[SW-1:0];
    found    = 1'b0;
    free_idx = '0;
    // Lowest free slot of the row.
    for (int s = SLOTS_PER_CHANNEL - 1; s >= 0; s--) begin
      if (!rd_occ[s]) begin
        found    = 1'b1;
        free_idx = SW'(s);
      end
    end

    wr_c          = 1'b0;
    clr_c         = 1'b0;
    wr_occ        = rd_occ;
    wr_gen        = rd_gen;
    next_gen_next = next_gen;
    mark_next     = mark;
    rej_next      = rej;
    total_next    = total;
    acc_c         = 1'b0;
    o_ch_c        = '0;
    o_slot_c      = '0;
    o_gen_c       = '0;
    o_act_c       = 1'b0;

    case (op_q)
      OP_SUBSCRIBE: begin
        if (ch_ok && found) begin
          wr_c             = 1'b1;
          wr_occ[free_idx] = 1'b1;
          wr_gen[free_idx] = next_gen;
          next_gen_next    = next_gen + 1'b1;
          total_next       = total + 1'b1;
          // A nonempty channel always sits below the mark, so a plain max works.
          if (32'(ch_q) >= 32'(mark)) begin
            mark_next = MW'(32'(ch_q) + 32'd1);
          end
          acc_c    = 1'b1;
          o_ch_c   = ch_q;
          o_slot_c = HSLOT_W'(free_idx);
          o_gen_c  = next_gen;
          o_act_c  = 1'b1;
        end else begin
          rej_next = rej + 1'b1;
        end
      end
      OP_UNSUBSCRIBE: begin
        if (hact_q && ch_ok && slot_ok && rd_occ[hs_idx] && (rd_gen[hs_idx] == hgen_q)) begin
          wr_c           = 1'b1;
          wr_occ[hs_idx] = 1'b0;
          total_next     = total - 1'b1;
          acc_c          = 1'b1;
        end
      end
      OP_CLEAR: begin
        clr_c      = 1'b1;
        mark_next  = '0;
        rej_next   = '0;
        total_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, counters and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid_q <= 1'b0;
      next_gen    <= GEN_W'(1);
      mark        <= '0;
      rej         <= '0;
      total       <= '0;
    end else begin
      if (rsp_valid_q && rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_xfer) begin
            op_q    <= req.operation;
            ch_q    <= req.channel;
            hslot_q <= req.handle_slot;
            hgen_q  <= req.handle_generation;
            hact_q  <= req.handle_active;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          next_gen    <= next_gen_next;
          mark        <= mark_next;
          rej         <= rej_next;
          total       <= total_next;
          rsp_valid_q <= 1'b1;
          o_acc_q     <= acc_c;
          o_ch_q      <= o_ch_c;
          o_slot_q    <= o_slot_c;
          o_gen_q     <= o_gen_c;
          o_act_q     <= o_act_c;
          o_total_q   <= total_next;
          o_mark_q    <= mark_next;
          o_rej_q     <= rej_next;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid           = rsp_valid_q;
  assign rsp.accepted        = o_acc_q;
  assign rsp.out_channel     = o_ch_q;
  assign rsp.out_slot        = o_slot_q;
  assign rsp.out_generation  = o_gen_q;
  assign rsp.out_active      = o_act_q;
  assign rsp.total_handlers  = TOTAL_OUT_W'(o_total_q);
  assign rsp.channels_in_use = INUSE_OUT_W'(o_mark_q);
  assign rsp.rejected_count  = o_rej_q;

endmodule

// ===== sv/gsr_checker.sv =====
// ----------------------------------------------------------------------------
// gsr_checker
// Port-level checks of the slot registry, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsr_checker import gsr_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic [OP_W-1:0]        req_operation,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input logic                   rsp_accepted,
  input logic                   rsp_out_active,
  input logic [TOTAL_OUT_W-1:0] rsp_total_handlers,
  input logic [INUSE_OUT_W-1:0] rsp_channels_in_use,
  input logic [REJ_W-1:0]       rsp_rejected_count
);

  // Reset empties the result register.
  `GSR_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !rsp_valid, "result valid after reset")

  // A waiting result is held until it transfers.
  `GSR_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")

  // The row write-back cycle blocks a new request.
  `GSR_ASSERT(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready, "request overlap")

  // A clear yields its result with all counts at zero.
  `GSR_ASSERT(a_clear_result, clk, rst,
    req_valid && req_ready && (req_operation == OP_CLEAR) |-> ##2
    (rsp_valid && !rsp_accepted && !rsp_out_active && (rsp_total_handlers == '0) &&
     (rsp_channels_in_use == '0) && (rsp_rejected_count == '0)), "bad clear result")

endmodule

bind generational_slot_registry_unit gsr_checker u_gsr_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .req_operation       (req.operation),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_accepted        (rsp.accepted),
  .rsp_out_active      (rsp.out_active),
  .rsp_total_handlers  (rsp.total_handlers),
  .rsp_channels_in_use (rsp.channels_in_use),
  .rsp_rejected_count  (rsp.rejected_count)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot registry testbench
// Drives subscribe, unsubscribe, clear and the unused command code into the
// registry. A short table of hand-picked commands comes first, then about 650
// random ones that mostly subscribe to a few busy channels and release live
// handles. Each command is predicted by a behavioral copy of the registry.
// Every result is compared field by field with the oldest expected result, taken from the table where a row gives one.
// ----------------------------------------------------------------------------
module testbench import gsr_pkg::*; ();

  localparam int CHANNELS    = DEF_CHANNEL_COUNT;
  localparam int SLOTS       = DEF_SLOTS_PER_CHANNEL;
  localparam int RANDOM_CMDS = 217;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_ROWS    = 24;

  // Command code that the registry does not define.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CH_W-1:0]    channel;
    logic [HSLOT_W-1:0] handle_slot;
    logic [GEN_W-1:0]   handle_generation;
    logic               handle_active;
  } reg_cmd_t;

  typedef struct packed {
    logic                   accepted;
    logic [CH_W-1:0]        out_channel;
    logic [HSLOT_W-1:0]     out_slot;
    logic [GEN_W-1:0]       out_generation;
    logic                   out_active;
    logic [TOTAL_OUT_W-1:0] total_handlers;
    logic [INUSE_OUT_W-1:0] channels_in_use;
    logic [REJ_W-1:0]       rejected_count;
  } reg_result_t;

  typedef struct packed {
    reg_cmd_t    cmd;
    logic        typed;
    reg_result_t want;
  } dir_row_t;

  localparam reg_result_t UNTYPED = '0;

  logic clk;
  logic rst;

  gsr_req_if req ();
  gsr_rsp_if rsp ();

  generational_slot_registry_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Shadow copy of the registry state.
  bit          slot_busy  [CHANNELS*SLOTS];
  logic [31:0] slot_stamp [CHANNELS*SLOTS];
  int          chan_fill  [CHANNELS];
  logic [31:0] stamp_next;
  int          high_mark;
  logic [31:0] reject_tally;
  int          live_handles;

  reg_result_t pending_results [$];
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          snd_idle_pct   = 28;
  int          rcv_idle_pct   = 80;
  bit          hold_armed     = 1'b0;
  bit          hold_done      = 1'b0;

  // Hand-picked commands: extremes, each command code and each ignored case.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{'{OP_SUBSCRIBE, 8'd0, 4'd0, 32'd0, 1'b0}, 1'b1,
      '{1'b1, 8'd0, 4'd0, 32'd1, 1'b1, 10'd1, 7'd1, 32'd0}},
    '{'{OP_SUBSCRIBE, 8'd63, 4'd15, 32'hFFFF_FFFF, 1'b1}, 1'b1,
      '{1'b1, 8'd63, 4'd0, 32'd2, 1'b1, 10'd2, 7'd64, 32'd0}},
    '{'{OP_SUBSCRIBE, 8'd64, 4'd0, 32'd0, 1'b0}, 1'b1,
      '{1'b0, 8'd0, 4'd0, 32'd0, 1'b0, 10'd2, 7'd64, 32'd1}},
    '{'{OP_SUBSCRIBE, 8'd255, 4'd0, 32'd0, 1'b0}, 1'b1,
      '{1'b0, 8'd0, 4'd0, 32'd0, 1'b0, 10'd2, 7'd64, 32'd2}},
    '{'{OP_SUBSCRIBE, 8'd0, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_SUBSCRIBE, 8'd0, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_SUBSCRIBE, 8'd0, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_SUBSCRIBE, 8'd0, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_SUBSCRIBE, 8'd0, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_SUBSCRIBE, 8'd0, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_SUBSCRIBE, 8'd0, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    // Channel zero is full now.
    '{'{OP_SUBSCRIBE, 8'd0, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_UNSUBSCRIBE, 8'd0, 4'd0, 32'd1, 1'b1}, 1'b0, UNTYPED},
    // Releases that must be ignored: free slot, stale stamp, inactive handle,
    // slot out of range, channel out of range.
    '{'{OP_UNSUBSCRIBE, 8'd0, 4'd0, 32'd1, 1'b1}, 1'b0, UNTYPED},
    '{'{OP_UNSUBSCRIBE, 8'd0, 4'd1, 32'hFFFF_FFFF, 1'b1}, 1'b0, UNTYPED},
    '{'{OP_UNSUBSCRIBE, 8'd0, 4'd1, 32'd3, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_UNSUBSCRIBE, 8'd0, 4'd15, 32'd0, 1'b1}, 1'b0, UNTYPED},
    '{'{OP_UNSUBSCRIBE, 8'd255, 4'd0, 32'd1, 1'b1}, 1'b0, UNTYPED},
    '{'{OP_SUBSCRIBE, 8'd0, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_UNUSED, 8'hAA, 4'hA, 32'hAAAA_AAAA, 1'b1}, 1'b0, UNTYPED},
    '{'{OP_CLEAR, 8'hFF, 4'hF, 32'hFFFF_FFFF, 1'b1}, 1'b1,
      '{1'b0, 8'd0, 4'd0, 32'd0, 1'b0, 10'd0, 7'd0, 32'd0}},
    // The generation keeps counting across the clear.
    '{'{OP_SUBSCRIBE, 8'd5, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_SUBSCRIBE, 8'd2, 4'd0, 32'd0, 1'b0}, 1'b0, UNTYPED},
    '{'{OP_UNSUBSCRIBE, 8'd63, 4'd0, 32'd2, 1'b1}, 1'b0, UNTYPED}
  };

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Empties every channel; the generation counter is left alone.
  function automatic void registry_clear();
    int i;
    for (i = 0; i < CHANNELS*SLOTS; i++) begin
      slot_busy[i]  = 1'b0;
      slot_stamp[i] = '0;
    end
    for (i = 0; i < CHANNELS; i++) begin
      chan_fill[i] = 0;
    end
    high_mark    = 0;
    reject_tally = '0;
    live_handles = 0;
  endfunction

  // Applies one command to the shadow state and returns the result it gives.
  function automatic reg_result_t registry_apply(input reg_cmd_t c);
    reg_result_t r;
    int          idx;
    int          s;
    bit          placed;
    r      = '0;
    placed = 1'b0;
    if (c.op == OP_SUBSCRIBE) begin
      if (c.channel < CHANNELS) begin
        for (s = 0; s < SLOTS; s++) begin
          idx = c.channel * SLOTS + s;
          if (!placed && !slot_busy[idx]) begin
            slot_busy[idx]  = 1'b1;
            slot_stamp[idx] = stamp_next;
            stamp_next      = stamp_next + 32'd1;
            chan_fill[c.channel]++;
            live_handles++;
            if (chan_fill[c.channel] == 1 && c.channel >= high_mark) begin
              high_mark = c.channel + 1;
            end
            r.accepted       = 1'b1;
            r.out_channel    = c.channel;
            r.out_slot       = HSLOT_W'(s);
            r.out_generation = slot_stamp[idx];
            r.out_active     = 1'b1;
            placed           = 1'b1;
          end
        end
      end
      if (!placed) begin
        reject_tally = reject_tally + 32'd1;
      end
    end else if (c.op == OP_UNSUBSCRIBE) begin
      if (c.handle_active && c.channel < CHANNELS && c.handle_slot < SLOTS) begin
        idx = c.channel * SLOTS + c.handle_slot;
        if (slot_busy[idx] && slot_stamp[idx] == c.handle_generation) begin
          slot_busy[idx] = 1'b0;
          if (chan_fill[c.channel] > 0) chan_fill[c.channel]--;
          if (live_handles > 0) live_handles--;
          r.accepted = 1'b1;
        end
      end
    end else if (c.op == OP_CLEAR) begin
      registry_clear();
    end
    r.total_handlers  = TOTAL_OUT_W'(live_handles);
    r.channels_in_use = INUSE_OUT_W'(high_mark);
    r.rejected_count  = reject_tally;
    return r;
  endfunction

  // Mostly a few busy channels so that they fill up, sometimes any value.
  function automatic logic [CH_W-1:0] pick_channel();
    int unsigned roll;
    int unsigned hot;
    roll = $urandom_range(99);
    hot  = $urandom_range(7);
    if (roll < 75) return CH_W'((hot < 4) ? hot : 56 + hot);
    if (roll < 90) return CH_W'($urandom_range(CHANNELS - 1));
    return CH_W'($urandom_range(255));
  endfunction

  // Random command; most releases carry the stamp of a real slot.
  function automatic reg_cmd_t pick_command();
    reg_cmd_t    c;
    int unsigned roll;
    int          idx;
    roll                = $urandom_range(99);
    c.op                = OP_SUBSCRIBE;
    c.channel           = pick_channel();
    c.handle_slot       = HSLOT_W'($urandom_range(15));
    c.handle_generation = $urandom;
    c.handle_active     = 1'($urandom_range(1));
    if (roll >= 48 && roll < 93) begin
      c.op = OP_UNSUBSCRIBE;
      if (roll < 83) begin
        c.handle_slot   = HSLOT_W'($urandom_range(SLOTS - 1));
        c.handle_active = 1'b1;
        if (c.channel < CHANNELS) begin
          idx                 = c.channel * SLOTS + c.handle_slot;
          c.handle_generation = slot_stamp[idx];
        end
      end
    end else if (roll >= 93 && roll < 96) begin
      c.op = OP_CLEAR;
    end else if (roll >= 96) begin
      c.op = OP_UNUSED;
    end
    return c;
  endfunction

  // Idle cycles of the sender before the next command.
  task automatic sender_gap();
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < snd_idle_pct) n++;
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offers one command and records its expected result once it transfers.
  task automatic offer(input reg_cmd_t c, input logic typed, input reg_result_t want);
    reg_result_t predicted;
    req.operation         <= c.op;
    req.channel           <= c.channel;
    req.handle_slot       <= c.handle_slot;
    req.handle_generation <= c.handle_generation;
    req.handle_active     <= c.handle_active;
    req.valid             <= 1'b1;
    do @(posedge clk); while (req.ready !== 1'b1);
    predicted = registry_apply(c);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Lets every outstanding result arrive before going on.
  task automatic drain_results();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    int i;
    int phase;
    rst                   <= 1'b1;
    req.valid             <= 1'b0;
    req.operation         <= OP_SUBSCRIBE;
    req.channel           <= '0;
    req.handle_slot       <= '0;
    req.handle_generation <= '0;
    req.handle_active     <= 1'b0;
    registry_clear();
    stamp_next = 32'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      sender_gap();
      offer(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    // Three random phases: slow receiver, slow sender, then no random idling but one long receiver hold-off.
    for (phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 80 : 0;
      rcv_idle_pct <= (phase == 0) ? 80 : (phase == 1) ? 28 : 0;
      if (phase == 2) hold_armed <= 1'b1;
      for (i = 0; i < RANDOM_CMDS; i++) begin
        sender_gap();
        offer(pick_command(), 1'b0, UNTYPED);
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result check on every response transfer.
  always @(posedge clk) begin
    reg_result_t want;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no result pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("accepted", 32'(want.accepted), 32'(rsp.accepted));
        compare_field("out_channel", 32'(want.out_channel), 32'(rsp.out_channel));
        compare_field("out_slot", 32'(want.out_slot), 32'(rsp.out_slot));
        compare_field("out_generation", want.out_generation, rsp.out_generation);
        compare_field("out_active", 32'(want.out_active), 32'(rsp.out_active));
        compare_field("total_handlers", 32'(want.total_handlers),
                      32'(rsp.total_handlers));
        compare_field("channels_in_use", 32'(want.channels_in_use),
                      32'(rsp.channels_in_use));
        compare_field("rejected_count", want.rejected_count, rsp.rejected_count);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

endmodule
